/* design/pvc_pkg.sv */
`timescale 1ns / 1ps

package pvc_pkg;

	// Fixed scaling of the control law
	localparam int ERR_LIMIT  = 2000;
	localparam int FULL_SCALE = 12800;
	localparam int TOP_SCALE  = 25600;

	// Reciprocal unit: 12800 fits in 14 bits, one quotient bit per step
	localparam int QUOT_W     = 14;
	localparam int DIV_STEPS  = QUOT_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

	// Program counter of the sequencer
	localparam int PC_W = 4;

	// Configuration register indexes
	localparam logic [2:0] CFG_PROP_GAIN  = 3'd0;
	localparam logic [2:0] CFG_INT_GAIN   = 3'd1;
	localparam logic [2:0] CFG_QUAD_GAIN  = 3'd2;
	localparam logic [2:0] CFG_VALVE_UPPER = 3'd3;
	localparam logic [2:0] CFG_VALVE_LOWER = 3'd4;
	localparam logic [2:0] CFG_HOLD_BAND  = 3'd5;

	// Datapath operations
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_DIV,
		OP_INTEG,
		OP_CLAMP,
		OP_MULA,
		OP_ADDP,
		OP_MULB,
		OP_SHIFT,
		OP_MULC,
		OP_SUM,
		OP_OUT
	} op_t;

	// Condition that lets a step advance
	typedef enum logic [1:0] {
		C_NONE,
		C_IN,
		C_DIV,
		C_OUT
	} cond_t;

	// Divisor picked when a step starts the reciprocal unit
	typedef enum logic [1:0] {
		DS_NONE,
		DS_PROP,
		DS_INT
	} dsel_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		dsel_t dsel;
		logic  last;
	} cw_t;

	typedef struct packed {
		logic       start;
		logic [7:0] divisor;
	} div_ctrl_t;

	typedef struct packed {
		logic              busy;
		logic [QUOT_W-1:0] quot;
	} div_stat_t;

	// Control store: one word per step
	function automatic cw_t ucode(input logic [PC_W-1:0] pc);
		cw_t w;
		case (pc)
			4'd0:  w = '{op: OP_LOAD,  cond: C_IN,   dsel: DS_PROP, last: 1'b0};
			4'd1:  w = '{op: OP_DIV,   cond: C_DIV,  dsel: DS_NONE, last: 1'b0};
			4'd2:  w = '{op: OP_INTEG, cond: C_NONE, dsel: DS_INT,  last: 1'b0};
			4'd3:  w = '{op: OP_DIV,   cond: C_DIV,  dsel: DS_NONE, last: 1'b0};
			4'd4:  w = '{op: OP_CLAMP, cond: C_NONE, dsel: DS_NONE, last: 1'b0};
			4'd5:  w = '{op: OP_MULA,  cond: C_NONE, dsel: DS_NONE, last: 1'b0};
			4'd6:  w = '{op: OP_ADDP,  cond: C_NONE, dsel: DS_NONE, last: 1'b0};
			4'd7:  w = '{op: OP_MULB,  cond: C_NONE, dsel: DS_NONE, last: 1'b0};
			4'd8:  w = '{op: OP_SHIFT, cond: C_NONE, dsel: DS_NONE, last: 1'b0};
			4'd9:  w = '{op: OP_MULC,  cond: C_NONE, dsel: DS_NONE, last: 1'b0};
			4'd10: w = '{op: OP_SUM,   cond: C_NONE, dsel: DS_NONE, last: 1'b0};
			4'd11: w = '{op: OP_OUT,   cond: C_OUT,  dsel: DS_NONE, last: 1'b1};
			default: w = '{op: OP_NOP, cond: C_NONE, dsel: DS_NONE, last: 1'b1};
		endcase
		return w;
	endfunction

endpackage

/* design/pvc_div.sv */
`timescale 1ns / 1ps

module pvc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  pvc_pkg::div_ctrl_t  ctrl,
	output pvc_pkg::div_stat_t  stat
);

	localparam logic [pvc_pkg::QUOT_W-1:0] DIVIDEND = pvc_pkg::QUOT_W'(pvc_pkg::FULL_SCALE);

	logic [pvc_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [pvc_pkg::QUOT_W-1:0]    num_q;
	logic [pvc_pkg::QUOT_W-1:0]    quot_q;
	logic [7:0]                    rem_q;
	logic [7:0]                    div_q;
	logic [8:0]                    trial;
	logic [8:0]                    diff;
	logic                          qbit;

	// Trial subtract for one quotient bit
	assign trial = {rem_q, num_q[pvc_pkg::QUOT_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign qbit  = (trial >= {1'b0, div_q});

	// Restoring division of the full-scale constant, one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.start) begin
			cnt_q <= pvc_pkg::DIV_CNT_W'(pvc_pkg::DIV_STEPS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			num_q  <= DIVIDEND;
			rem_q  <= '0;
			quot_q <= '0;
			div_q  <= ctrl.divisor;
		end else if (cnt_q != '0) begin
			num_q  <= {num_q[pvc_pkg::QUOT_W-2:0], 1'b0};
			rem_q  <= qbit ? diff[7:0] : trial[7:0];
			quot_q <= {quot_q[pvc_pkg::QUOT_W-2:0], qbit};
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign stat.quot = quot_q;

endmodule

/* design/nonlinear_pi_valve_controller.sv */
`timescale 1ns / 1ps

// PI valve controller with a quadratic proportional term and anti-windup.
// Input channel (in_valid / in_stall) carries target_temp, measured_temp and
// previous_valve; output channel (out_valid / out_stall) carries the new
// valve_position in percent. One result per input item.
// Gains, valve limits and hold band are written through cfg_valid /
// cfg_ready / cfg_index / cfg_data; the user must write them only while no
// item is in flight, as the block does not enforce it. cfg_ready is always
// high and unknown indexes are dropped.
// An item runs through the microcode steps from accept to result, with two
// waits on the bit-serial reciprocal unit (14 quotient bits each,
// 12800/prop_gain and 12800/integral_gain). The next item can be taken in
// the cycle after the result is loaded. One item is in work at a time;
// in_stall is high from accept until the sequencer returns to its first step.
// A finished result sits in the output register while the next item runs;
// if the receiver still stalls when the next result is ready, the sequencer
// holds at its last step until the register is taken.
// Reset sets the configuration registers to their defaults, clears the integral
// sum and the stored measurement (no temperature history), and empties the output.
module nonlinear_pi_valve_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic signed [15:0] target_temp,
	input  logic signed [15:0] measured_temp,
	input  logic [6:0]        previous_valve,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [6:0]        valve_position,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [7:0]        cfg_data
);

	// Configuration
	logic [7:0] prop_gain_q;
	logic [7:0] int_gain_q;
	logic [7:0] quad_gain_q;
	logic [6:0] valve_upper_q;
	logic [6:0] valve_lower_q;
	logic [7:0] hold_band_q;

	// Sequencer
	logic [pvc_pkg::PC_W-1:0] pc_q;
	pvc_pkg::cw_t              cw;
	logic                      in_acc;
	logic                      out_free;
	logic                      adv;

	// Datapath
	logic signed [15:0] last_meas_q;
	logic signed [15:0] esum_q;
	logic signed [11:0] err_q;
	logic               move_q;
	logic [6:0]         prev_q;
	logic signed [31:0] prod_q;
	logic signed [31:0] acc_q;
	logic               out_valid_q;
	logic [6:0]         out_q;

	pvc_pkg::div_ctrl_t div_ctrl;
	pvc_pkg::div_stat_t div_st;

	logic signed [16:0] diff_tm;
	logic signed [16:0] diff_lm;
	logic signed [11:0] err_new;
	logic               move_new;
	logic [11:0]        err_neg;
	logic [10:0]        abs_err;
	logic signed [15:0] lim;
	logic signed [15:0] err16;
	logic signed [15:0] step;
	logic signed [15:0] esum_clamp;
	logic signed [20:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [37:0] mul_p;
	logic [14:0]        p15;
	logic signed [16:0] span;
	logic [16:0]        span_neg;
	logic [15:0]        adist;
	logic [6:0]         scaled;
	logic [6:0]         result;

	assign cw        = pvc_pkg::ucode(pc_q);
	assign in_stall  = (cw.cond != pvc_pkg::C_IN);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign valve_position = out_q;

	// Step advance condition
	always_comb begin
		case (cw.cond)
			pvc_pkg::C_IN:  adv = in_acc;
			pvc_pkg::C_DIV: adv = !div_st.busy;
			pvc_pkg::C_OUT: adv = out_free;
			default:        adv = 1'b1;
		endcase
	end

	// Start the reciprocal unit; a zero gain divides by one
	always_comb begin
		div_ctrl.start   = adv && (cw.dsel != pvc_pkg::DS_NONE);
		div_ctrl.divisor = 8'd1;
		case (cw.dsel)
			pvc_pkg::DS_PROP:
				div_ctrl.divisor = (prop_gain_q == '0) ? 8'd1 : prop_gain_q;
			pvc_pkg::DS_INT:
				div_ctrl.divisor = (int_gain_q == '0) ? 8'd1 : int_gain_q;
			default:
				div_ctrl.divisor = 8'd1;
		endcase
	end

	pvc_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (div_ctrl),
		.stat  (div_st)
	);

	// Error clamp and movement test on the incoming item
	always_comb begin
		diff_tm = {target_temp[15], target_temp} - {measured_temp[15], measured_temp};
		diff_lm = {last_meas_q[15], last_meas_q} - {measured_temp[15], measured_temp};
		if (diff_tm > 17'sd2000) begin
			err_new = 12'(pvc_pkg::ERR_LIMIT);
		end else if (diff_tm < -17'sd2000) begin
			err_new = -12'(pvc_pkg::ERR_LIMIT);
		end else begin
			err_new = diff_tm[11:0];
		end
		move_new = (last_meas_q != '0) &&
			((diff_lm > 17'sd0 && err_new > 12'sd0) ||
			 (diff_lm < 17'sd0 && err_new < 12'sd0));
	end

	// Integral step and sum clamp against the current quotient
	always_comb begin
		err_neg    = -err_q;
		abs_err    = err_q[11] ? err_neg[10:0] : err_q[10:0];
		lim        = $signed({2'b00, div_st.quot});
		err16      = {{4{err_q[11]}}, err_q};
		if (err16 > lim) begin
			step = lim;
		end else if (err16 < -lim) begin
			step = -lim;
		end else begin
			step = err16;
		end
		if (esum_q > lim) begin
			esum_clamp = lim;
		end else if (esum_q < -lim) begin
			esum_clamp = -lim;
		end else begin
			esum_clamp = esum_q;
		end
	end

	// Shared multiplier operands
	always_comb begin
		case (cw.op)
			pvc_pkg::OP_MULA: begin
				mul_a = $signed({13'd0, quad_gain_q});
				mul_b = $signed({6'd0, abs_err});
			end
			pvc_pkg::OP_MULB: begin
				mul_a = acc_q[20:0];
				mul_b = {{5{err_q[11]}}, err_q};
			end
			pvc_pkg::OP_MULC: begin
				mul_a = $signed({13'd0, int_gain_q});
				mul_b = {esum_q[15], esum_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// Map the raw sum to a valve position
	always_comb begin
		p15      = acc_q[14:0];
		span     = $signed({2'b00, p15}) - $signed({2'b00, prev_q, 8'd0});
		span_neg = -span;
		adist    = span[16] ? span_neg[15:0] : span[15:0];
		scaled   = p15[14:8];
		if (acc_q > 32'(pvc_pkg::TOP_SCALE)) begin
			result = valve_upper_q;
		end else if (acc_q[31]) begin
			result = valve_lower_q;
		end else if (adist < {8'd0, hold_band_q}) begin
			result = prev_q;
		end else if (scaled > valve_upper_q) begin
			result = valve_upper_q;
		end else if (scaled < valve_lower_q) begin
			result = valve_lower_q;
		end else begin
			result = scaled;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q   <= 8'd1;
			int_gain_q    <= 8'd0;
			quad_gain_q   <= 8'd0;
			valve_upper_q <= 7'd100;
			valve_lower_q <= 7'd0;
			hold_band_q   <= 8'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pvc_pkg::CFG_PROP_GAIN:   prop_gain_q   <= cfg_data;
				pvc_pkg::CFG_INT_GAIN:    int_gain_q    <= cfg_data;
				pvc_pkg::CFG_QUAD_GAIN:   quad_gain_q   <= cfg_data;
				pvc_pkg::CFG_VALVE_UPPER: valve_upper_q <= cfg_data[6:0];
				pvc_pkg::CFG_VALVE_LOWER: valve_lower_q <= cfg_data[6:0];
				pvc_pkg::CFG_HOLD_BAND:   hold_band_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Step counter, controller state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= '0;
			last_meas_q <= '0;
			esum_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				pc_q <= cw.last ? '0 : pc_q + 1'b1;
			end
			if (cw.op == pvc_pkg::OP_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (cw.op)
				pvc_pkg::OP_LOAD: begin
					if (in_acc) begin
						last_meas_q <= measured_temp;
					end
				end
				pvc_pkg::OP_INTEG: begin
					if (move_q) begin
						esum_q <= esum_q + step;
					end
				end
				pvc_pkg::OP_CLAMP: esum_q <= esum_clamp;
				default: ;
			endcase
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		case (cw.op)
			pvc_pkg::OP_LOAD: begin
				if (in_acc) begin
					err_q  <= err_new;
					move_q <= move_new;
					prev_q <= previous_valve;
				end
			end
			pvc_pkg::OP_MULA,
			pvc_pkg::OP_MULB,
			pvc_pkg::OP_MULC:  prod_q <= mul_p[31:0];
			pvc_pkg::OP_ADDP:  acc_q  <= prod_q + $signed({16'd0, prop_gain_q, 8'd0});
			pvc_pkg::OP_SHIFT: acc_q  <= prod_q >>> 8;
			pvc_pkg::OP_SUM:   acc_q  <= acc_q + prod_q + 32'(pvc_pkg::FULL_SCALE);
			pvc_pkg::OP_OUT: begin
				if (out_free) begin
					out_q <= result;
				end
			end
			default: ;
		endcase
	end

	// The reciprocal unit runs only under a wait step
	a_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.busy |-> (cw.op == pvc_pkg::OP_DIV))
		else $error("reciprocal unit busy outside a wait step");

	// The integral sum is clamped between items
	a_esum_range: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == '0) |-> (esum_q <= 16'sd12800 && esum_q >= -16'sd12800))
		else $error("integral sum out of range between items");

	// The working error stays within its clamp during an item
	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q != '0) |-> (err_q <= 12'sd2000 && err_q >= -12'sd2000))
		else $error("clamped error out of range");

	// Leaving the last step always loads the output register
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(cw.op == pvc_pkg::OP_OUT && out_free) |=> (out_valid_q && pc_q == '0))
		else $error("result step left without loading output");

endmodule
